// ===== rtl/core/wsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int unsigned CFG_W = 17;
    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 17'h10000;

    localparam logic REQ_DATA    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [2:0] MASK_BYTES = 3'd4;

    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXTLEN  = 6'b000100,
        PH_MASK    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_DISCARD = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [3:0] frame_opcode;
        logic [7:0] data_byte;
        logic       last_of_frame;
    } t_res_pl;

    typedef struct packed {
        logic    valid;
        t_res_pl pl;
    } t_res;

endpackage

// ===== rtl/core/wsd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_in_if
// Input byte channel: request type and received stream byte.
// ----------------------------------------------------------------------------
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

// ===== rtl/core/wsd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_out_if
// Result channel: payload bytes, empty-frame and error results.
// ----------------------------------------------------------------------------
interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [3:0] frame_opcode;
    logic [7:0] data_byte;
    logic       last_of_frame;

    modport source (output valid, output result_kind, output frame_opcode,
                    output data_byte, output last_of_frame, input ready);
    modport sink (input valid, input result_kind, input frame_opcode,
                  input data_byte, input last_of_frame, output ready);
endinterface

// ===== rtl/core/wsd_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_cfg_if
// Configuration write channel for the maximum payload length register.
// ----------------------------------------------------------------------------
interface wsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/wsd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser
// Header parse state machine, length check and payload unmasking.
// ----------------------------------------------------------------------------
module wsd_parser
    import wsd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_accept,
    input  logic             i_req_type,
    input  logic [7:0]       i_rx_byte,
    output t_res             o_res
);

    t_phase           r_phase, n_phase;
    logic [CFG_W-1:0] r_max;
    logic [3:0]       r_opcode, n_opcode;
    logic             r_mask, n_mask;
    logic [3:0]       r_ext, n_ext;
    logic [2:0]       r_mleft, n_mleft;
    logic [31:0]      r_key, n_key;
    logic [63:0]      r_len, n_len;
    logic [CFG_W-1:0] r_remain, n_remain;
    logic [1:0]       r_midx, n_midx;
    t_res             n_res;

    always_comb begin
        logic       do_after;
        logic       do_hdr;
        logic [7:0] b;
        logic [7:0] kb;
        do_after = 1'b0;
        do_hdr   = 1'b0;
        b        = i_rx_byte;
        kb       = '0;
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_mask   = r_mask;
        n_ext    = r_ext;
        n_mleft  = r_mleft;
        n_key    = r_key;
        n_len    = r_len;
        n_remain = r_remain;
        n_midx   = r_midx;
        n_res    = '0;
        n_res.pl.frame_opcode = r_opcode;
        if (i_accept) begin
            if (i_req_type == REQ_RESTART) begin
                n_phase  = PH_HDR0;
                n_opcode = '0;
                n_mask   = 1'b0;
                n_ext    = '0;
                n_mleft  = '0;
                n_key    = '0;
                n_len    = '0;
                n_remain = '0;
                n_midx   = '0;
            end else begin
                unique case (r_phase)
                    PH_HDR0: begin
                        n_opcode = b[3:0];
                        n_phase  = PH_HDR1;
                    end
                    PH_HDR1: begin
                        n_mask = b[7];
                        n_len  = '0;
                        if (b[6:0] == LEN_CODE_16) begin
                            n_ext   = EXT_BYTES_16;
                            n_phase = PH_EXTLEN;
                        end else if (b[6:0] == LEN_CODE_64) begin
                            n_ext   = EXT_BYTES_64;
                            n_phase = PH_EXTLEN;
                        end else begin
                            n_len    = {57'd0, b[6:0]};
                            do_after = 1'b1;
                        end
                    end
                    PH_EXTLEN: begin
                        n_len = {r_len[55:0], b};
                        if (r_ext != 4'd0) begin
                            n_ext = r_ext - 4'd1;
                        end
                        do_after = (n_ext == 4'd0);
                    end
                    PH_MASK: begin
                        n_key = {r_key[23:0], b};
                        if (r_mleft != 3'd0) begin
                            n_mleft = r_mleft - 3'd1;
                        end
                        do_hdr = (n_mleft == 3'd0);
                    end
                    PH_PAYLOAD: begin
                        case (r_midx)
                            2'd0:    kb = r_key[31:24];
                            2'd1:    kb = r_key[23:16];
                            2'd2:    kb = r_key[15:8];
                            default: kb = r_key[7:0];
                        endcase
                        n_res.valid            = 1'b1;
                        n_res.pl.result_kind   = KIND_DATA;
                        n_res.pl.data_byte     = r_mask ? (b ^ kb) : b;
                        n_midx                 = r_midx + 2'd1;
                        n_remain               = r_remain - {{(CFG_W-1){1'b0}}, 1'b1};
                        if (r_remain == {{(CFG_W-1){1'b0}}, 1'b1}) begin
                            n_res.pl.last_of_frame = 1'b1;
                            n_phase                = PH_HDR0;
                        end
                    end
                    PH_DISCARD: begin
                        n_phase = PH_DISCARD;
                    end
                    default: begin
                        n_phase = PH_DISCARD;
                    end
                endcase
                if (do_after) begin
                    if (n_mask) begin
                        n_mleft = MASK_BYTES;
                        n_key   = '0;
                        n_phase = PH_MASK;
                    end else begin
                        do_hdr = 1'b1;
                    end
                end
                if (do_hdr) begin
                    n_midx   = '0;
                    n_remain = n_len[CFG_W-1:0];
                    if (n_len >= {{(64-CFG_W){1'b0}}, r_max}) begin
                        n_phase              = PH_DISCARD;
                        n_res.valid          = 1'b1;
                        n_res.pl.result_kind = KIND_ERROR;
                    end else if (n_len == 64'd0) begin
                        n_phase                = PH_HDR0;
                        n_res.valid            = 1'b1;
                        n_res.pl.result_kind   = KIND_EMPTY;
                        n_res.pl.last_of_frame = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_max    <= MAX_LEN_RESET;
            r_opcode <= '0;
            r_mask   <= 1'b0;
            r_ext    <= '0;
            r_mleft  <= '0;
            r_key    <= '0;
            r_len    <= '0;
            r_remain <= '0;
            r_midx   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_mask   <= n_mask;
            r_ext    <= n_ext;
            r_mleft  <= n_mleft;
            r_key    <= n_key;
            r_len    <= n_len;
            r_remain <= n_remain;
            r_midx   <= n_midx;
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
        end
    end

    assign o_res = n_res;

endmodule

// ===== rtl/core/wsd_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_out_buf
// Result register with a skid stage so the parser keeps taking bytes while
// one result waits for the receiver.
// ----------------------------------------------------------------------------
module wsd_out_buf
    import wsd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_res  i_res,
    output logic  o_space,
    wsd_out_if.source o_res
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_res_pl r_main;
    t_res_pl r_skid;
    logic    pop;

    assign pop     = r_main_valid && o_res.ready;
    assign o_space = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= i_res.valid;
            end else begin
                r_main_valid <= i_res.valid;
            end
        end else if (i_res.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
                r_skid <= i_res.pl;
            end else begin
                r_main <= i_res.pl;
            end
        end else if (i_res.valid) begin
            r_skid <= i_res.pl;
        end
    end

    assign o_res.valid         = r_main_valid;
    assign o_res.result_kind   = r_main.result_kind;
    assign o_res.frame_opcode  = r_main.frame_opcode;
    assign o_res.data_byte     = r_main.data_byte;
    assign o_res.last_of_frame = r_main.last_of_frame;

endmodule

// ===== rtl/core/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Splits a received byte stream into WebSocket frames and unmasks payloads.
//
// i_rx carries one transfer per received byte, or a restart request that
// clears all parse state. o_res carries one transfer per payload byte, per
// empty frame and per length error; header bytes give no transfer except the
// one that completes the header of an empty or too-long frame. i_cfg writes
// the maximum payload length; it is always ready and is meant to be written
// while the block is idle. A byte is taken every cycle while i_rx.ready is
// high, and its result is registered. A result register and a one-entry
// skid stage part the two sides, so one result may wait while the next byte
// comes in; i_rx.ready drops only when both hold a result, and rises again
// once the receiver takes one. After an error every byte is dropped until a
// restart. Reset clears the parse state, empties both result stages and sets
// the maximum payload length to 65536.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    wsd_in_if.sink    i_rx,
    wsd_cfg_if.sink   i_cfg,
    wsd_out_if.source o_res
);

    t_res res;
    logic space;
    logic accept;

    assign i_rx.ready  = space;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_rx.valid && space;

    wsd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .i_accept   (accept),
        .i_req_type (i_rx.req_type),
        .i_rx_byte  (i_rx.rx_byte),
        .o_res      (res)
    );

    wsd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_space (space),
        .o_res   (o_res)
    );

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.result_kind != KIND_DATA) |-> o_res.data_byte == 8'd0)
        else $error("non-data result carries a data byte");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.result_kind == KIND_ERROR) |-> !o_res.last_of_frame)
        else $error("error result marked as last of frame");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.result_kind == KIND_EMPTY) |-> o_res.last_of_frame)
        else $error("empty-frame result not marked as last");

    a_no_result_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_rx.req_type == REQ_RESTART) |-> !res.valid)
        else $error("restart produced a result");

endmodule

// ===== tb/websocket_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// Self-checking regression for the WebSocket frame deframer. A short table of
// hand-written bytes covers the header forms and the error path, then random
// frames, broken frames and noise run under several maximum payload lengths.
// Every accepted byte is fed to a bit-level predictor of the parser, and every
// result transfer is checked in order against the predicted or typed-in ones.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;
    import wsd_pkg::*;

    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 4;
    localparam int DRAIN_GUARD  = 20000;
    localparam int N_DIRECTED   = 27;

    typedef struct {
        logic       req;
        logic [7:0] rx;
        bit         exact;
        t_res_pl    want;
    } t_dir_row;

    logic clk;
    logic rst_n;

    wsd_in_if  rx_if ();
    wsd_cfg_if cfg_if ();
    wsd_out_if res_if ();

    websocket_frame_deframer uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // Typed-in expectations travel with the byte they belong to.
    logic    row_exact;
    t_res_pl row_want;

    t_res_pl     expected_results [$];
    int unsigned mismatches;
    int unsigned items_sent;
    logic [16:0] cur_max;
    bit          idle_on;
    bit          gappy;
    bit          hold_results;

    t_phase      rx_phase;
    logic [3:0]  rx_opcode;
    logic        rx_masked;
    logic [3:0]  ext_left;
    logic [2:0]  key_left;
    logic [31:0] mask_key;
    logic [63:0] frame_len;
    logic [63:0] bytes_done;
    logic [16:0] max_len;

    t_dir_row dir_rows [N_DIRECTED] = '{
        '{REQ_DATA,    8'h00, 1'b0, '0},
        '{REQ_DATA,    8'h00, 1'b1, '{KIND_EMPTY, 4'h0, 8'h00, 1'b1}},
        '{REQ_DATA,    8'hFF, 1'b0, '0},
        '{REQ_DATA,    8'h81, 1'b0, '0},
        '{REQ_DATA,    8'hFF, 1'b0, '0},
        '{REQ_DATA,    8'hFF, 1'b0, '0},
        '{REQ_DATA,    8'hFF, 1'b0, '0},
        '{REQ_DATA,    8'hFF, 1'b0, '0},
        '{REQ_DATA,    8'h00, 1'b1, '{KIND_DATA, 4'hF, 8'hFF, 1'b1}},
        '{REQ_DATA,    8'h82, 1'b0, '0},
        '{REQ_DATA,    8'h7F, 1'b0, '0},
        '{REQ_DATA,    8'hFF, 1'b0, '0},
        '{REQ_DATA,    8'hFF, 1'b0, '0},
        '{REQ_DATA,    8'hFF, 1'b0, '0},
        '{REQ_DATA,    8'hFF, 1'b0, '0},
        '{REQ_DATA,    8'hFF, 1'b0, '0},
        '{REQ_DATA,    8'hFF, 1'b0, '0},
        '{REQ_DATA,    8'hFF, 1'b0, '0},
        '{REQ_DATA,    8'hFF, 1'b1, '{KIND_ERROR, 4'h2, 8'h00, 1'b0}},
        '{REQ_DATA,    8'h55, 1'b0, '0},
        '{REQ_RESTART, 8'h00, 1'b0, '0},
        '{REQ_DATA,    8'h01, 1'b0, '0},
        '{REQ_DATA,    8'h7E, 1'b0, '0},
        '{REQ_DATA,    8'h00, 1'b0, '0},
        '{REQ_DATA,    8'h02, 1'b0, '0},
        '{REQ_DATA,    8'h41, 1'b0, '0},
        '{REQ_DATA,    8'hBE, 1'b0, '0}
    };

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void clear_parse();
        rx_phase   = PH_HDR0;
        rx_opcode  = '0;
        rx_masked  = 1'b0;
        ext_left   = '0;
        key_left   = '0;
        mask_key   = '0;
        frame_len  = '0;
        bytes_done = '0;
    endfunction

    function automatic bit end_of_header(output t_res_pl r);
        r = '0;
        r.frame_opcode = rx_opcode;
        bytes_done = '0;
        if (frame_len >= 64'(max_len)) begin
            rx_phase = PH_DISCARD;
            r.result_kind = KIND_ERROR;
            return 1'b1;
        end
        if (frame_len == 64'd0) begin
            rx_phase = PH_HDR0;
            r.result_kind = KIND_EMPTY;
            r.last_of_frame = 1'b1;
            return 1'b1;
        end
        rx_phase = PH_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic bit deframe_byte(input logic req, input logic [7:0] b,
                                        output t_res_pl r);
        bit         len_done;
        bit         got;
        int         k;
        logic [7:0] d;
        len_done = 1'b0;
        got = 1'b0;
        r = '0;
        d = b;
        if (req == REQ_RESTART) begin
            clear_parse();
            return 1'b0;
        end
        case (rx_phase)
            PH_HDR0: begin
                rx_opcode = b[3:0];
                rx_phase = PH_HDR1;
            end
            PH_HDR1: begin
                rx_masked = b[7];
                frame_len = '0;
                if (b[6:0] == LEN_CODE_16) begin
                    ext_left = EXT_BYTES_16;
                    rx_phase = PH_EXTLEN;
                end else if (b[6:0] == LEN_CODE_64) begin
                    ext_left = EXT_BYTES_64;
                    rx_phase = PH_EXTLEN;
                end else begin
                    frame_len = 64'(b[6:0]);
                    len_done = 1'b1;
                end
            end
            PH_EXTLEN: begin
                frame_len = {frame_len[55:0], b};
                if (ext_left != 0) ext_left--;
                len_done = (ext_left == 0);
            end
            PH_MASK: begin
                mask_key = {mask_key[23:0], b};
                if (key_left != 0) key_left--;
                if (key_left == 0) got = end_of_header(r);
            end
            PH_PAYLOAD: begin
                if (rx_masked) begin
                    k = 3 - int'(bytes_done[1:0]);
                    d = b ^ mask_key[8*k +: 8];
                end
                bytes_done++;
                r.result_kind = KIND_DATA;
                r.frame_opcode = rx_opcode;
                r.data_byte = d;
                r.last_of_frame = (bytes_done >= frame_len);
                if (r.last_of_frame) rx_phase = PH_HDR0;
                got = 1'b1;
            end
            default: rx_phase = PH_DISCARD;
        endcase
        if (len_done) begin
            if (rx_masked) begin
                key_left = MASK_BYTES;
                mask_key = '0;
                rx_phase = PH_MASK;
            end else begin
                got = end_of_header(r);
            end
        end
        return got;
    endfunction

    task automatic flag_mismatch(input string what, input t_res_pl want,
                                 input t_res_pl got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch, %s: expected kind=%0d op=%h data=%h last=%b",
                     what, want.result_kind, want.frame_opcode, want.data_byte,
                     want.last_of_frame);
            $display("    actual kind=%0d op=%h data=%h last=%b",
                     got.result_kind, got.frame_opcode, got.data_byte,
                     got.last_of_frame);
        end
    endtask

    always @(posedge clk) begin : monitor
        t_res_pl predicted;
        t_res_pl want;
        t_res_pl got;
        bit      has;
        if (!rst_n) begin
            clear_parse();
            max_len = MAX_LEN_RESET;
        end else begin
            if (cfg_if.valid && cfg_if.ready) max_len = cfg_if.data;
            if (rx_if.valid && rx_if.ready) begin
                has = deframe_byte(rx_if.req_type, rx_if.rx_byte, predicted);
                if (row_exact) expected_results.push_back(row_want);
                else if (has) expected_results.push_back(predicted);
            end
            if (res_if.valid && res_if.ready) begin
                got = '{res_if.result_kind, res_if.frame_opcode, res_if.data_byte,
                        res_if.last_of_frame};
                if (expected_results.size() == 0) begin
                    flag_mismatch("no result expected", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.result_kind !== want.result_kind ||
                        got.frame_opcode !== want.frame_opcode ||
                        got.data_byte !== want.data_byte ||
                        got.last_of_frame !== want.last_of_frame) begin
                        flag_mismatch("wrong result", want, got);
                    end
                end
            end
        end
    end

    initial begin
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_results) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic send_item(input logic req, input logic [7:0] b,
                             input bit exact, input t_res_pl want);
        rx_if.valid <= 1'b1;
        rx_if.req_type <= req;
        rx_if.rx_byte <= b;
        row_exact <= exact;
        row_want <= want;
        do @(posedge clk); while (!rx_if.ready);
        items_sent++;
        if (gappy && idle_on && $urandom_range(0, 5) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(REQ_DATA, b, 1'b0, '0);
    endtask

    task automatic send_restart();
        send_item(REQ_RESTART, 8'($urandom), 1'b0, '0);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        rx_if.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (expected_results.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [16:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        cur_max = value;
    endtask

    task automatic send_frame(input bit truncate);
        logic [7:0]  seq [$];
        logic        masked;
        logic [6:0]  code;
        logic [63:0] flen;
        int unsigned pick;
        int unsigned cut;
        bit          err;
        masked = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        seq.push_back(8'($urandom));
        if (pick < 60) begin
            flen = 64'($urandom_range(0, 20));
            code = flen[6:0];
        end else if (pick < 66) begin
            flen = 64'($urandom_range(21, 125));
            code = flen[6:0];
        end else if (pick < 78) begin
            flen = 64'($urandom_range(0, 40));
            code = LEN_CODE_16;
        end else if (pick < 86) begin
            flen = 64'($urandom_range(0, 40));
            code = LEN_CODE_64;
        end else if (pick < 93 && cur_max <= 17'd65535) begin
            flen = 64'($urandom_range(int'(cur_max), 65535));
            code = LEN_CODE_16;
        end else begin
            flen = {$urandom, $urandom};
            if (flen < 64'(cur_max)) flen[63] = 1'b1;
            code = LEN_CODE_64;
        end
        seq.push_back({masked, code});
        if (code == LEN_CODE_16) begin
            seq.push_back(flen[15:8]);
            seq.push_back(flen[7:0]);
        end else if (code == LEN_CODE_64) begin
            for (int i = 7; i >= 0; i--) seq.push_back(flen[8*i +: 8]);
        end
        if (masked) begin
            for (int i = 0; i < 4; i++) seq.push_back(8'($urandom));
        end
        err = (flen >= 64'(cur_max));
        if (!err) begin
            for (int i = 0; i < int'(flen); i++) seq.push_back(8'($urandom));
        end
        if (truncate) begin
            cut = $urandom_range(1, seq.size() - 1);
            for (int i = 0; i < int'(cut); i++) send_byte(seq[i]);
            send_restart();
        end else begin
            foreach (seq[i]) send_byte(seq[i]);
            if (err) begin
                repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
                send_restart();
            end
        end
    endtask

    task automatic send_sequence();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        gappy = ($urandom_range(0, 2) != 0);
        if (pick < 8) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            send_restart();
        end else if (pick < 14) begin
            send_frame(1'b1);
        end else if (pick < 17) begin
            send_restart();
        end else begin
            send_frame(1'b0);
        end
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < n) send_sequence();
    endtask

    initial begin
        rst_n <= 1'b0;
        rx_if.valid <= 1'b0;
        rx_if.req_type <= REQ_DATA;
        rx_if.rx_byte <= '0;
        row_exact <= 1'b0;
        row_want <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        mismatches = 0;
        items_sent = 0;
        cur_max = MAX_LEN_RESET;
        idle_on = 1'b1;
        gappy = 1'b0;
        hold_results = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_item(dir_rows[i].req, dir_rows[i].rx, dir_rows[i].exact,
                      dir_rows[i].want);
        end
        send_restart();
        wait_idle();

        run_random(200);
        hold_results = 1'b1;
        gappy = 1'b0;
        run_random(250);
        wait_idle();
        run_random(100);
        wait_idle();

        write_max_len(17'd20);
        run_random(150);
        wait_idle();
        write_max_len(17'd0);
        run_random(100);
        wait_idle();
        write_max_len(17'd1);
        run_random(100);
        wait_idle();
        write_max_len(17'h1FFFF);
        run_random(150);

        // One frame of 256 bytes behind a 64-bit length code, so the byte
        // counter runs past 8 bits.
        idle_on = 1'b0;
        send_byte(8'h82);
        send_byte({1'b1, LEN_CODE_64});
        for (int i = 7; i >= 0; i--) send_byte(i == 1 ? 8'h01 : 8'h00);
        repeat (4) send_byte(8'($urandom));
        repeat (256) send_byte(8'($urandom));
        idle_on = 1'b1;
        wait_idle();

        write_max_len(17'($urandom_range(2, 300)));
        run_random(250);
        wait_idle();
        write_max_len(MAX_LEN_RESET);
        idle_on = 1'b0;
        run_random(150);
        wait_idle();

        if (expected_results.size() != 0) begin
            flag_mismatch("result never arrived", expected_results[0], '0);
        end
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
